/* rtl/acmm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acmm_pkg - shared types and constants of the channel matrix mixer
// Sample and frame types, coefficient codes, status codes, pipeline control.
// ----------------------------------------------------------------------------
package acmm_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int LANES               = 6;
  localparam int MAX_CHANNELS        = 6;
  localparam int COEF_FRAC_BITS_DEF  = 14;
  // headroom of a lane accumulator over sample x coefficient
  localparam int ACC_GUARD_W         = 5;

  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 1'b1;

  localparam int COEF_CODE_W = 3;
  typedef logic [COEF_CODE_W-1:0] coef_code_t;
  localparam coef_code_t COEF_ZERO    = 3'd0;
  localparam coef_code_t COEF_ONE     = 3'd1;
  localparam coef_code_t COEF_RSQRT2  = 3'd2;
  localparam coef_code_t COEF_HALF    = 3'd3;
  localparam coef_code_t COEF_QUARTER = 3'd4;

  typedef enum logic [1:0] {
    STATUS_MIXED       = 2'd0,
    STATUS_PASS        = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } mix_status_t;

  typedef logic [LANES-1:0][SAMPLE_W-1:0]    frame_t;
  typedef logic [LANES-1:0][COEF_CODE_W-1:0] lane_codes_t;
  typedef lane_codes_t [LANES-1:0]           code_matrix_t;

  typedef struct packed {
    code_matrix_t codes;   // [output lane][input lane]
    mix_status_t  status;
  } decode_t;

  typedef struct packed {
    logic s1;   // products
    logic s2;   // pair sums
    logic s3;   // lane sum
  } pipe_en_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample_0;
    logic signed [SAMPLE_W-1:0] in_sample_1;
    logic signed [SAMPLE_W-1:0] in_sample_2;
    logic signed [SAMPLE_W-1:0] in_sample_3;
    logic signed [SAMPLE_W-1:0] in_sample_4;
    logic signed [SAMPLE_W-1:0] in_sample_5;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample_0;
    logic signed [SAMPLE_W-1:0] out_sample_1;
    logic signed [SAMPLE_W-1:0] out_sample_2;
    logic signed [SAMPLE_W-1:0] out_sample_3;
    logic signed [SAMPLE_W-1:0] out_sample_4;
    logic signed [SAMPLE_W-1:0] out_sample_5;
    logic [1:0]                 mix_status;
  } out_frame_t;

endpackage
`default_nettype wire

/* rtl/acmm_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acmm_stream_if - valid/ready stream channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface acmm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

/* rtl/acmm_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acmm_decode - layout registers and coefficient matrix decode
// Holds the two layout counts and turns them into a code per lane pair.
// ----------------------------------------------------------------------------
module acmm_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [acmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output acmm_pkg::decode_t               dec
);
  import acmm_pkg::*;

  localparam logic [1:0] LAYOUT_MONO   = 2'd0;
  localparam logic [1:0] LAYOUT_STEREO = 2'd1;
  localparam logic [1:0] LAYOUT_QUAD   = 2'd2;
  localparam logic [1:0] LAYOUT_SURR   = 2'd3;

  localparam logic [CFG_DATA_W-1:0] CH_RESET = 3'd2;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } layout_t;

  function automatic layout_t layout_of(input logic [CFG_DATA_W-1:0] n);
    layout_t l;
    l.ok  = 1'b1;
    l.idx = LAYOUT_MONO;
    case (n)
      3'd1:    l.idx = LAYOUT_MONO;
      3'd2:    l.idx = LAYOUT_STEREO;
      3'd4:    l.idx = LAYOUT_QUAD;
      3'd6:    l.idx = LAYOUT_SURR;
      default: l.ok  = 1'b0;
    endcase
    return l;
  endfunction

  // fixed mixing matrices, j = output lane, i = input lane
  function automatic coef_code_t mix_code(input logic [1:0] li, input logic [1:0] lo,
                                          input logic [2:0] j, input logic [2:0] i);
    coef_code_t c;
    c = COEF_ZERO;
    case ({li, lo})
      {LAYOUT_MONO, LAYOUT_STEREO}, {LAYOUT_MONO, LAYOUT_QUAD}: begin
        if (i == 3'd0 && j <= 3'd1) c = COEF_ONE;
      end
      {LAYOUT_MONO, LAYOUT_SURR}: begin
        if (i == 3'd0 && j == 3'd2) c = COEF_ONE;
      end
      {LAYOUT_STEREO, LAYOUT_MONO}: begin
        if (j == 3'd0 && i <= 3'd1) c = COEF_HALF;
      end
      {LAYOUT_STEREO, LAYOUT_QUAD}, {LAYOUT_STEREO, LAYOUT_SURR}: begin
        if (j <= 3'd1 && i == j) c = COEF_ONE;
      end
      {LAYOUT_QUAD, LAYOUT_MONO}: begin
        if (j == 3'd0 && i <= 3'd3) c = COEF_QUARTER;
      end
      {LAYOUT_QUAD, LAYOUT_STEREO}: begin
        if (j <= 3'd1 && (i == j || i == j + 3'd2)) c = COEF_HALF;
      end
      {LAYOUT_QUAD, LAYOUT_SURR}: begin
        if ((j <= 3'd1 && i == j) || (j >= 3'd4 && j <= 3'd5 && i == j - 3'd2))
          c = COEF_ONE;
      end
      {LAYOUT_SURR, LAYOUT_MONO}: begin
        if (j == 3'd0) begin
          case (i)
            3'd0, 3'd1: c = COEF_RSQRT2;
            3'd2:       c = COEF_ONE;
            3'd4, 3'd5: c = COEF_HALF;
            default:    c = COEF_ZERO;   // LFE dropped
          endcase
        end
      end
      {LAYOUT_SURR, LAYOUT_STEREO}: begin
        if (j <= 3'd1) begin
          if (i == j) c = COEF_ONE;
          else if (i == 3'd2 || i == j + 3'd4) c = COEF_RSQRT2;
        end
      end
      {LAYOUT_SURR, LAYOUT_QUAD}: begin
        if (j <= 3'd1) begin
          if (i == j) c = COEF_ONE;
          else if (i == 3'd2) c = COEF_RSQRT2;
        end else if ((j == 3'd2 && i == 3'd4) || (j == 3'd3 && i == 3'd5)) begin
          c = COEF_ONE;
        end
      end
      default: c = COEF_ZERO;
    endcase
    return c;
  endfunction

  logic [CFG_DATA_W-1:0] in_ch_r;
  logic [CFG_DATA_W-1:0] out_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r  <= CH_RESET;
      out_ch_r <= CH_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IN_CHANNELS:  in_ch_r  <= cfg_wdata;
        CFG_OUT_CHANNELS: out_ch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  layout_t li;
  layout_t lo;
  logic    pass;
  logic    mixable;

  always_comb begin
    li      = layout_of(in_ch_r);
    lo      = layout_of(out_ch_r);
    pass    = (in_ch_r == out_ch_r) && (in_ch_r != '0) &&
              ({1'b0, in_ch_r} <= 4'(MAX_CHANNELS));
    mixable = (in_ch_r != out_ch_r) && li.ok && lo.ok;

    if (pass)         dec.status = STATUS_PASS;
    else if (mixable) dec.status = STATUS_MIXED;
    else              dec.status = STATUS_UNSUPPORTED;

    // pass-through is unity on the diagonal, so every case runs the same datapath
    for (int j = 0; j < LANES; j++) begin
      for (int i = 0; i < LANES; i++) begin
        if (pass)
          dec.codes[j][i] = (i == j && 3'(i) < in_ch_r) ? COEF_ONE : COEF_ZERO;
        else if (mixable)
          dec.codes[j][i] = mix_code(li.idx, lo.idx, 3'(j), 3'(i));
        else
          dec.codes[j][i] = COEF_ZERO;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/acmm_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acmm_lane - one output lane of the mixing matrix
// Six products, pairwise adds, then the full lane sum; one register each.
// ----------------------------------------------------------------------------
module acmm_lane #(
  parameter  int COEF_FRAC_BITS = acmm_pkg::COEF_FRAC_BITS_DEF,
  localparam int ACC_W = acmm_pkg::SAMPLE_W + COEF_FRAC_BITS + acmm_pkg::ACC_GUARD_W
) (
  input  logic                    clk,
  input  acmm_pkg::pipe_en_t      en,
  input  acmm_pkg::frame_t        samples,
  input  acmm_pkg::lane_codes_t   codes,
  output logic signed [ACC_W-1:0] sum_o
);
  import acmm_pkg::*;

  localparam int CW    = COEF_FRAC_BITS + 2;
  localparam int PW    = SAMPLE_W + CW;
  localparam int PAIRS = LANES / 2;

  localparam int C_ONE_I    = 1 << COEF_FRAC_BITS;
  localparam int C_RSQRT2_I = (7071 * C_ONE_I + 5000) / 10000;

  localparam logic signed [CW-1:0] C_ONE     = CW'(C_ONE_I);
  localparam logic signed [CW-1:0] C_RSQRT2  = CW'(C_RSQRT2_I);
  localparam logic signed [CW-1:0] C_HALF    = CW'(C_ONE_I >> 1);
  localparam logic signed [CW-1:0] C_QUARTER = CW'(C_ONE_I >> 2);

  function automatic logic signed [CW-1:0] coef_of(input coef_code_t code);
    logic signed [CW-1:0] v;
    case (code)
      COEF_ONE:     v = C_ONE;
      COEF_RSQRT2:  v = C_RSQRT2;
      COEF_HALF:    v = C_HALF;
      COEF_QUARTER: v = C_QUARTER;
      default:      v = '0;
    endcase
    return v;
  endfunction

  logic signed [PW-1:0]    prod_r [LANES];
  logic signed [PW:0]      pair_r [PAIRS];
  logic signed [ACC_W-1:0] sum_nxt;
  logic signed [ACC_W-1:0] sum_r;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < PAIRS; k++)
      sum_nxt = sum_nxt + ACC_W'(pair_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < LANES; i++)
        prod_r[i] <= PW'($signed(samples[i])) * PW'(coef_of(codes[i]));
    end
    if (en.s2) begin
      for (int k = 0; k < PAIRS; k++)
        pair_r[k] <= (PW+1)'(prod_r[2*k]) + (PW+1)'(prod_r[2*k+1]);
    end
    if (en.s3) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule
`default_nettype wire

/* rtl/acmm_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acmm_merge - scaling, saturation and output register
// Scales every lane sum back to sample range and packs the result beat.
// ----------------------------------------------------------------------------
module acmm_merge #(
  parameter  int COEF_FRAC_BITS = acmm_pkg::COEF_FRAC_BITS_DEF,
  localparam int ACC_W = acmm_pkg::SAMPLE_W + COEF_FRAC_BITS + acmm_pkg::ACC_GUARD_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [ACC_W-1:0] sums [acmm_pkg::LANES],
  input  acmm_pkg::mix_status_t   status,
  output logic                    ready_o,
  acmm_stream_if.source           out_frame
);
  import acmm_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((1 << COEF_FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);

  // divide by 2^F toward zero, then clamp
  function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    t = s[ACC_W-1] ? s + RND_BIAS : s;
    q = t >>> COEF_FRAC_BITS;
    if (q > SAT_MAX)      return SAT_MAX[SAMPLE_W-1:0];
    else if (q < SAT_MIN) return SAT_MIN[SAMPLE_W-1:0];
    else                  return q[SAMPLE_W-1:0];
  endfunction

  logic                out_v_r;
  logic [SAMPLE_W-1:0] res_r [LANES];
  mix_status_t         status_r;

  assign ready_o = !out_v_r || out_frame.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ready_o) begin
      out_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      for (int j = 0; j < LANES; j++)
        res_r[j] <= scale_sat(sums[j]);
      status_r <= status;
    end
  end

  assign out_frame.valid             = out_v_r;
  assign out_frame.data.out_sample_0 = res_r[0];
  assign out_frame.data.out_sample_1 = res_r[1];
  assign out_frame.data.out_sample_2 = res_r[2];
  assign out_frame.data.out_sample_3 = res_r[3];
  assign out_frame.data.out_sample_4 = res_r[4];
  assign out_frame.data.out_sample_5 = res_r[5];
  assign out_frame.data.mix_status   = status_r;

  a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_frame.valid && out_frame.data.mix_status == STATUS_UNSUPPORTED) |->
      (res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0 &&
       res_r[3] == '0 && res_r[4] == '0 && res_r[5] == '0))
    else $error("unsupported layout beat carries non-zero samples");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_o && in_valid) |=> out_v_r)
    else $error("lane result taken but output register empty");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_o |-> out_v_r)
    else $error("merge stage stalls while empty");

endmodule
`default_nettype wire

/* rtl/audio_channel_matrix_mixer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// audio_channel_matrix_mixer_unit - channel layout matrix mixer, top level
// Remaps a frame of six samples between mono, stereo, quad and 5.1 layouts.
// ----------------------------------------------------------------------------
// Throughput: one frame per cycle unless the output stalls, set by the six
//   parallel lane pipelines (multiply, pair add, lane sum) and the saturating
//   output register.
// Reset: synchronous, clears all valid flags and sets both layouts to stereo;
//   no clearing pass, frames are accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module audio_channel_matrix_mixer_unit #(
  parameter int COEF_FRAC_BITS = acmm_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [acmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  acmm_stream_if.sink                     in_frame,
  acmm_stream_if.source                   out_frame
);
  import acmm_pkg::*;

  localparam int ACC_W = SAMPLE_W + COEF_FRAC_BITS + ACC_GUARD_W;

  decode_t                 dec;
  frame_t                  samples;
  pipe_en_t                en;
  logic                    merge_ready;
  logic signed [ACC_W-1:0] sums [LANES];

  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  mix_status_t st1_status_r;
  mix_status_t st2_status_r;
  mix_status_t st3_status_r;

  acmm_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .dec       (dec)
  );

  assign samples[0] = in_frame.data.in_sample_0;
  assign samples[1] = in_frame.data.in_sample_1;
  assign samples[2] = in_frame.data.in_sample_2;
  assign samples[3] = in_frame.data.in_sample_3;
  assign samples[4] = in_frame.data.in_sample_4;
  assign samples[5] = in_frame.data.in_sample_5;

  // a stage moves up whenever the one after it is empty or moving
  assign en.s3 = !v3_r || merge_ready;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;
  assign in_frame.ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_frame.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) st1_status_r <= dec.status;
    if (en.s2) st2_status_r <= st1_status_r;
    if (en.s3) st3_status_r <= st2_status_r;
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    acmm_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .samples (samples),
      .codes   (dec.codes[j]),
      .sum_o   (sums[j])
    );
  end

  acmm_merge #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .sums      (sums),
    .status    (st3_status_r),
    .ready_o   (merge_ready),
    .out_frame (out_frame)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame.valid && in_frame.ready) |=> v1_r)
    else $error("accepted beat did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !merge_ready) |=> (v3_r && $stable(st3_status_r)))
    else $error("last lane stage lost or changed a stalled beat");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame.ready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a bubble in the pipeline");

endmodule
`default_nettype wire

/* tb/audio_channel_matrix_mixer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_channel_matrix_mixer_unit_tb - self-checking bench for the layout mixer
// Walks a short table of directed frames, then random frames over many layout
// settings, with random idling on both streams and one long output stall.
// Every output beat is checked lane by lane against a typed or modelled result.
// ----------------------------------------------------------------------------
module audio_channel_matrix_mixer_unit_tb;
  import acmm_pkg::*;

  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  STALL_CYCLES   = 250;
  localparam int  RANDOM_FRAMES  = 1150;
  localparam longint ONE_Q       = longint'(1) << COEF_FRAC_BITS_DEF;
  localparam longint HALF_Q      = ONE_Q >> 1;
  localparam longint QUARTER_Q   = ONE_Q >> 2;
  localparam longint RSQRT2_Q    = (7071 * ONE_Q + 5000) / 10000;

  typedef enum logic [2:0] {
    LAY_MONO,
    LAY_STEREO,
    LAY_QUAD,
    LAY_SURROUND,
    LAY_NONE
  } layout_t;

  typedef struct {
    logic [2:0] src_ch;
    logic [2:0] dst_ch;
    in_frame_t  frame;
    bit         typed;
    out_frame_t want;
  } frame_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  acmm_stream_if #(.payload_t(in_frame_t))  in_if ();
  acmm_stream_if #(.payload_t(out_frame_t)) out_if ();

  audio_channel_matrix_mixer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_frame  (in_if),
    .out_frame (out_if)
  );

  out_frame_t pending_frames[$];
  out_frame_t beat_want;
  logic [2:0] cur_src_ch;
  logic [2:0] cur_dst_ch;
  int  items_sent;
  int  frames_checked;
  int  mismatch_count;
  int  layout_writes;
  int  hold_left;
  bit  stall_req;
  bit  src_steady;
  bit  snk_steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic layout_t layout_of(logic [2:0] ch);
    case (ch)
      3'd1: return LAY_MONO;
      3'd2: return LAY_STEREO;
      3'd4: return LAY_QUAD;
      3'd6: return LAY_SURROUND;
      default: return LAY_NONE;
    endcase
  endfunction

  // weight code of input lane i into output lane o
  function automatic coef_code_t mix_coef(layout_t src, layout_t dst, int o, int i);
    coef_code_t c;
    c = COEF_ZERO;
    case (src)
      LAY_MONO: begin
        if ((dst == LAY_STEREO || dst == LAY_QUAD) && o < 2 && i == 0) c = COEF_ONE;
        if (dst == LAY_SURROUND && o == 2 && i == 0) c = COEF_ONE;
      end
      LAY_STEREO: begin
        if (dst == LAY_MONO && o == 0 && i < 2) c = COEF_HALF;
        if ((dst == LAY_QUAD || dst == LAY_SURROUND) && o < 2 && i == o) c = COEF_ONE;
      end
      LAY_QUAD: begin
        if (dst == LAY_MONO && o == 0 && i < 4) c = COEF_QUARTER;
        if (dst == LAY_STEREO && o < 2 && (i == o || i == o + 2)) c = COEF_HALF;
        if (dst == LAY_SURROUND && ((o < 2 && i == o) || (o >= 4 && i == o - 2)))
          c = COEF_ONE;
      end
      LAY_SURROUND: begin
        // LFE (lane 3) never reaches a downmix
        if (dst == LAY_MONO && o == 0) begin
          if (i < 2) c = COEF_RSQRT2;
          else if (i == 2) c = COEF_ONE;
          else if (i >= 4) c = COEF_HALF;
        end
        if (dst == LAY_STEREO && o < 2) begin
          if (i == o) c = COEF_ONE;
          else if (i == 2 || i == o + 4) c = COEF_RSQRT2;
        end
        if (dst == LAY_QUAD) begin
          if (o < 2 && i == o) c = COEF_ONE;
          else if (o < 2 && i == 2) c = COEF_RSQRT2;
          else if (o >= 2 && o < 4 && i == o + 2) c = COEF_ONE;
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic longint coef_weight(coef_code_t c);
    case (c)
      COEF_ONE:     return ONE_Q;
      COEF_RSQRT2:  return RSQRT2_Q;
      COEF_HALF:    return HALF_Q;
      COEF_QUARTER: return QUARTER_Q;
      default:      return 0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] in_lane(in_frame_t f, int k);
    case (k)
      0: return f.in_sample_0;
      1: return f.in_sample_1;
      2: return f.in_sample_2;
      3: return f.in_sample_3;
      4: return f.in_sample_4;
      default: return f.in_sample_5;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] out_lane(out_frame_t r, int k);
    case (k)
      0: return r.out_sample_0;
      1: return r.out_sample_1;
      2: return r.out_sample_2;
      3: return r.out_sample_3;
      4: return r.out_sample_4;
      default: return r.out_sample_5;
    endcase
  endfunction

  function automatic out_frame_t mix_frame(in_frame_t f, logic [2:0] src_ch,
                                           logic [2:0] dst_ch);
    layout_t src;
    layout_t dst;
    longint acc;
    logic signed [SAMPLE_W-1:0] lane [LANES];
    mix_status_t st;
    out_frame_t r;
    src = layout_of(src_ch);
    dst = layout_of(dst_ch);
    for (int k = 0; k < LANES; k++) lane[k] = '0;
    if (src_ch == dst_ch) begin
      if (src_ch >= 1 && src_ch <= MAX_CHANNELS) begin
        st = STATUS_PASS;
        for (int k = 0; k < LANES; k++)
          if (k < src_ch) lane[k] = in_lane(f, k);
      end else begin
        st = STATUS_UNSUPPORTED;
      end
    end else if (src == LAY_NONE || dst == LAY_NONE) begin
      st = STATUS_UNSUPPORTED;
    end else begin
      st = STATUS_MIXED;
      for (int o = 0; o < LANES; o++) begin
        if (o < dst_ch) begin
          acc = 0;
          for (int i = 0; i < LANES; i++)
            if (i < src_ch)
              acc += longint'(in_lane(f, i)) * coef_weight(mix_coef(src, dst, o, i));
          // signed divide truncates toward zero
          lane[o] = clamp16(acc / ONE_Q);
        end
      end
    end
    r.out_sample_0 = lane[0];
    r.out_sample_1 = lane[1];
    r.out_sample_2 = lane[2];
    r.out_sample_3 = lane[3];
    r.out_sample_4 = lane[4];
    r.out_sample_5 = lane[5];
    r.mix_status   = st;
    return r;
  endfunction

  // ------------------------------------------------------------ frame helpers
  function automatic in_frame_t make_frame(int s0, int s1, int s2, int s3, int s4,
                                           int s5);
    in_frame_t f;
    f.in_sample_0 = SAMPLE_W'(s0);
    f.in_sample_1 = SAMPLE_W'(s1);
    f.in_sample_2 = SAMPLE_W'(s2);
    f.in_sample_3 = SAMPLE_W'(s3);
    f.in_sample_4 = SAMPLE_W'(s4);
    f.in_sample_5 = SAMPLE_W'(s5);
    return f;
  endfunction

  function automatic out_frame_t make_result(int s0, int s1, int s2, int s3, int s4,
                                             int s5, mix_status_t st);
    out_frame_t r;
    r.out_sample_0 = SAMPLE_W'(s0);
    r.out_sample_1 = SAMPLE_W'(s1);
    r.out_sample_2 = SAMPLE_W'(s2);
    r.out_sample_3 = SAMPLE_W'(s3);
    r.out_sample_4 = SAMPLE_W'(s4);
    r.out_sample_5 = SAMPLE_W'(s5);
    r.mix_status   = st;
    return r;
  endfunction

  function automatic frame_row_t frame_row(int src, int dst, in_frame_t f, bit typed,
                                           out_frame_t want);
    frame_row_t row;
    row.src_ch = 3'(src);
    row.dst_ch = 3'(dst);
    row.frame  = f;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(64)) - 32;
      default: return int'(16'($urandom));
    endcase
  endfunction

  function automatic logic [2:0] pick_layout();
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(3))
        0: return 3'd1;
        1: return 3'd2;
        2: return 3'd4;
        default: return 3'd6;
      endcase
    end
    return 3'($urandom_range(7));
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_frame(input in_frame_t f, input out_frame_t want);
    while (!src_steady && $urandom_range(99) < 38) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.data  <= f;
    beat_want   <= want;
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // layouts change only with the pipeline drained
  task automatic set_layout(input logic [2:0] src, input logic [2:0] dst);
    in_if.valid <= 1'b0;
    while (frames_checked != items_sent) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IN_CHANNELS;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_idx   <= CFG_OUT_CHANNELS;
    cfg_wdata <= dst;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_src_ch  = src;
    cur_dst_ch  = dst;
    layout_writes++;
  endtask

  always @(posedge clk) begin
    if (stall_req) begin
      hold_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (snk_steady) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 38);
    end
  end

  // output beats are checked before the input beat of the same edge is logged
  always @(posedge clk) begin : scoreboard
    out_frame_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_frames.size() == 0) begin
        $error("output beat with no frame outstanding");
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        for (int k = 0; k < LANES; k++)
          if (out_lane(out_if.data, k) !== out_lane(want, k)) begin
            $error("out_sample_%0d: expected %0d, got %0d", k, out_lane(want, k),
                   out_lane(out_if.data, k));
            mismatch_count++;
          end
        if (out_if.data.mix_status !== want.mix_status) begin
          $error("mix_status: expected %0d, got %0d", want.mix_status,
                 out_if.data.mix_status);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) pending_frames.push_back(beat_want);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ----------------------------------------------------------------- sequence
  initial begin : stimulus
    frame_row_t rows[$];
    in_frame_t  f;
    out_frame_t want;
    int phase;
    int phase_len;
    int random_sent;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    beat_want      = '0;
    cur_src_ch     = 3'd2;
    cur_dst_ch     = 3'd2;
    items_sent     = 0;
    frames_checked = 0;
    mismatch_count = 0;
    layout_writes  = 0;
    hold_left      = 0;
    stall_req      = 1'b0;
    src_steady     = 1'b0;
    snk_steady     = 1'b0;

    // stereo pass-through straight out of reset
    rows.push_back(frame_row(2, 2, make_frame(32767, -32768, 1, 2, 3, 4), 1,
                             make_result(32767, -32768, 0, 0, 0, 0, STATUS_PASS)));
    rows.push_back(frame_row(2, 2, make_frame(-1, 0, -1, -1, -1, -1), 1,
                             make_result(-1, 0, 0, 0, 0, 0, STATUS_PASS)));
    // mono fan-out
    rows.push_back(frame_row(1, 2, make_frame(-32768, 5, 5, 5, 5, 5), 1,
                             make_result(-32768, -32768, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(1, 4, make_frame(1234, 9, 9, 9, 9, 9), 1,
                             make_result(1234, 1234, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(1, 6, make_frame(-77, 9, 9, 9, 9, 9), 1,
                             make_result(0, 0, -77, 0, 0, 0, STATUS_MIXED)));
    // -0.5 truncates to zero, not to -1
    rows.push_back(frame_row(2, 1, make_frame(-1, 0, 0, 0, 0, 0), 1,
                             make_result(0, 0, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(2, 1, make_frame(32767, 32767, 0, 0, 0, 0), 1,
                             make_result(32767, 0, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(2, 4, make_frame(100, -200, 7, 7, 7, 7), 0, '0));
    rows.push_back(frame_row(2, 6, make_frame(-32768, 32767, 7, 7, 7, 7), 0, '0));
    rows.push_back(frame_row(4, 1, make_frame(-1, -1, -1, -1, 9, 9), 1,
                             make_result(-1, 0, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(4, 2, make_frame(-32768, 32767, -32768, 32767, 1, 1), 0,
                             '0));
    rows.push_back(frame_row(4, 6, make_frame(11, -22, 33, -44, 55, 66), 0, '0));
    // full-scale 5.1 downmix clamps both ways
    rows.push_back(frame_row(6, 1, make_frame(32767, 32767, 32767, 32767, 32767, 32767),
                             1, make_result(32767, 0, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(6, 1, make_frame(-32768, -32768, -32768, -32768, -32768,
                             -32768), 1, make_result(-32768, 0, 0, 0, 0, 0, STATUS_MIXED)));
    // LFE alone vanishes in a downmix
    rows.push_back(frame_row(6, 2, make_frame(0, 0, 0, 32767, 0, 0), 1,
                             make_result(0, 0, 0, 0, 0, 0, STATUS_MIXED)));
    rows.push_back(frame_row(6, 2, make_frame(1000, -1000, 3000, 5, -7000, 20000), 0,
                             '0));
    rows.push_back(frame_row(6, 4, make_frame(32767, -32768, 32767, 3, -5, 32767), 0,
                             '0));
    rows.push_back(frame_row(6, 6, make_frame(1, 2, 3, 4, 5, 6), 1,
                             make_result(1, 2, 3, 4, 5, 6, STATUS_PASS)));
    // equal counts pass through, odd ones too, with upper lanes zeroed
    rows.push_back(frame_row(3, 3, make_frame(-3, 300, -30000, 8, 8, 8), 1,
                             make_result(-3, 300, -30000, 0, 0, 0, STATUS_PASS)));
    rows.push_back(frame_row(5, 5, make_frame(5, 4, 3, 2, 1, -1), 1,
                             make_result(5, 4, 3, 2, 1, 0, STATUS_PASS)));
    rows.push_back(frame_row(1, 1, make_frame(-32768, 1, 1, 1, 1, 1), 1,
                             make_result(-32768, 0, 0, 0, 0, 0, STATUS_PASS)));
    rows.push_back(frame_row(4, 4, make_frame(7, -7, 32767, -32768, 2, 2), 1,
                             make_result(7, -7, 32767, -32768, 0, 0, STATUS_PASS)));
    // unsupported pairs
    rows.push_back(frame_row(3, 2, make_frame(100, 100, 100, 100, 100, 100), 1,
                             make_result(0, 0, 0, 0, 0, 0, STATUS_UNSUPPORTED)));
    rows.push_back(frame_row(0, 0, make_frame(-1, -1, -1, -1, -1, -1), 1,
                             make_result(0, 0, 0, 0, 0, 0, STATUS_UNSUPPORTED)));
    rows.push_back(frame_row(7, 7, make_frame(32767, 1, 2, 3, 4, 5), 1,
                             make_result(0, 0, 0, 0, 0, 0, STATUS_UNSUPPORTED)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[n]) begin
      if (rows[n].src_ch != cur_src_ch || rows[n].dst_ch != cur_dst_ch)
        set_layout(rows[n].src_ch, rows[n].dst_ch);
      want = rows[n].typed ? rows[n].want
                           : mix_frame(rows[n].frame, cur_src_ch, cur_dst_ch);
      send_frame(rows[n].frame, want);
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_FRAMES) begin
      set_layout(pick_layout(), pick_layout());
      phase_len  = $urandom_range(30, 70);
      src_steady = 1'b0;
      snk_steady = 1'b0;
      if (phase == 4) begin
        // back-to-back on both sides
        phase_len  = 150;
        src_steady = 1'b1;
        snk_steady = 1'b1;
      end
      if (phase == 8) begin
        // sink holds off long enough for the pipeline to back up
        src_steady = 1'b1;
        stall_req  = 1'b1;
      end
      repeat (phase_len) begin
        f = make_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                       rand_sample(), rand_sample());
        send_frame(f, mix_frame(f, cur_src_ch, cur_dst_ch));
        random_sent++;
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (frames_checked != items_sent) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d frames over %0d layout settings, incl. odd and out-of-range",
             frames_checked, layout_writes);
    $display("%0d mismatches, %0d beats still outstanding", mismatch_count,
             pending_frames.size());
    if (mismatch_count == 0 && pending_frames.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
